### design/rs485q_pkg.sv
package rs485q_pkg;

	localparam int RING_SIZE = 64;
	localparam int PTR_W     = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
	localparam int BYTE_W    = 8;
	localparam int DELAY_W   = 16;
	localparam int SIL_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;
	localparam int MODE_W    = 3;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SIZE - 1);

	localparam logic [MODE_W-1:0] MODE_RX_BYTE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TX_READY = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TX_DONE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HOST_WR  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HOST_RD  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TICK     = 3'd5;
	localparam logic [MODE_W-1:0] MODE_CHK_TO   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_CLR_RX   = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_TX_DELAY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TO_RELOAD  = 1'd1;

	localparam logic [SIL_W-1:0] TO_RELOAD_RST = 8'd5;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

### design/rs485q_ram.sv
module rs485q_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/rs485_buffered_uart_queues.sv
// channel   signals                          transaction
// --------  -------------------------------  ---------------------------------
// input     in_valid/in_ready                mode, data_byte
// output    out_valid/out_ready              line_tx_*, host_rx_*, stored,
//                                            timeout_seen, driver_enable
// config    cfg_we, cfg_index, cfg_data      write only, no handshake
//
// In each input transaction the accept cycle updates pointers, timers and
// writes the ring; the next cycle picks up the registered ring read at the
// tail pointer and loads the output register.
// A new item is taken once the previous result has left or is leaving the
// output register. Reset (arst_n low) empties both rings and clears timers;
// ring contents are not cleared.
module rs485_buffered_uart_queues (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rs485q_pkg::MODE_W-1:0]      mode,
	input  logic [rs485q_pkg::BYTE_W-1:0]      data_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               line_tx_valid,
	output logic [rs485q_pkg::BYTE_W-1:0]      line_tx_byte,
	output logic                               host_rx_valid,
	output logic [rs485q_pkg::BYTE_W-1:0]      host_rx_byte,
	output logic                               stored,
	output logic                               timeout_seen,
	output logic                               driver_enable,
	input  logic                               cfg_we,
	input  logic [rs485q_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rs485q_pkg::CFG_W-1:0]       cfg_data
);

	import rs485q_pkg::*;

	logic [DELAY_W-1:0] tx_delay_q;
	logic [SIL_W-1:0]   to_reload_q;

	logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [DELAY_W-1:0] delay_left_q;
	logic [SIL_W-1:0]   silence_left_q;
	logic               timeout_pending_q;
	logic               line_driving_q;

	logic pend_s1;
	logic tx_pop_s1, rx_pop_s1, stored_s1, to_seen_s1, drv_s1;

	logic [BYTE_W-1:0] rx_rdata, tx_rdata;

	logic accept;
	logic rx_full, tx_full, rx_empty, tx_empty;
	logic rx_push, tx_push, rx_pop, tx_pop;
	logic drv_next;

	assign in_ready = !pend_s1 && (!out_valid || out_ready);
	assign accept   = in_valid && in_ready;

	assign rx_full  = ring_next(rx_head_q) == rx_tail_q;
	assign tx_full  = ring_next(tx_head_q) == tx_tail_q;
	assign rx_empty = rx_head_q == rx_tail_q;
	assign tx_empty = tx_head_q == tx_tail_q;

	assign rx_push = accept && mode == MODE_RX_BYTE && !line_driving_q && !rx_full;
	assign tx_push = accept && mode == MODE_HOST_WR && !tx_full;
	assign rx_pop  = accept && mode == MODE_HOST_RD && !rx_empty;
	assign tx_pop  = accept && mode == MODE_TX_READY && delay_left_q == '0 && !tx_empty;

	// line direction after this transaction
	assign drv_next = tx_pop ? 1'b1 :
		(mode == MODE_TX_DONE && tx_empty) ? 1'b0 : line_driving_q;

	rs485q_ram #(.WIDTH(BYTE_W), .DEPTH(RING_SIZE)) u_rx_ram (
		.clk   (clk),
		.we    (rx_push),
		.waddr (rx_head_q),
		.wdata (data_byte),
		.raddr (rx_tail_q),
		.rdata (rx_rdata)
	);

	rs485q_ram #(.WIDTH(BYTE_W), .DEPTH(RING_SIZE)) u_tx_ram (
		.clk   (clk),
		.we    (tx_push),
		.waddr (tx_head_q),
		.wdata (data_byte),
		.raddr (tx_tail_q),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_delay_q  <= '0;
			to_reload_q <= TO_RELOAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TX_DELAY:  tx_delay_q  <= cfg_data[DELAY_W-1:0];
				REG_TO_RELOAD: to_reload_q <= cfg_data[SIL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q         <= '0;
			rx_tail_q         <= '0;
			tx_head_q         <= '0;
			tx_tail_q         <= '0;
			delay_left_q      <= '0;
			silence_left_q    <= '0;
			timeout_pending_q <= 1'b0;
			line_driving_q    <= 1'b0;
			pend_s1           <= 1'b0;
			tx_pop_s1         <= 1'b0;
			rx_pop_s1         <= 1'b0;
			stored_s1         <= 1'b0;
			to_seen_s1        <= 1'b0;
			drv_s1            <= 1'b0;
		end else begin
			pend_s1 <= accept;
			if (accept) begin
				tx_pop_s1  <= tx_pop;
				rx_pop_s1  <= rx_pop;
				stored_s1  <= rx_push || tx_push;
				to_seen_s1 <= (mode == MODE_CHK_TO) && timeout_pending_q;
				drv_s1     <= drv_next;

				unique case (mode)
					MODE_RX_BYTE: begin
						if (!line_driving_q) begin
							silence_left_q <= to_reload_q;
							delay_left_q   <= tx_delay_q;
						end
						if (rx_push) begin
							rx_head_q <= ring_next(rx_head_q);
						end
					end
					MODE_TX_READY: begin
						if (tx_pop) begin
							tx_tail_q      <= ring_next(tx_tail_q);
							line_driving_q <= 1'b1;
						end
					end
					MODE_TX_DONE: begin
						if (tx_empty) begin
							line_driving_q <= 1'b0;
						end
					end
					MODE_HOST_WR: begin
						if (tx_push) begin
							tx_head_q <= ring_next(tx_head_q);
						end
					end
					MODE_HOST_RD: begin
						if (rx_pop) begin
							rx_tail_q <= ring_next(rx_tail_q);
						end
					end
					MODE_TICK: begin
						if (delay_left_q != '0) begin
							delay_left_q <= delay_left_q - DELAY_W'(1);
						end
						if (silence_left_q != '0) begin
							silence_left_q <= silence_left_q - SIL_W'(1);
							// flag fires on the tick that brings the counter to zero
							if (silence_left_q == SIL_W'(1)) begin
								timeout_pending_q <= 1'b1;
							end
						end
					end
					MODE_CHK_TO: begin
						timeout_pending_q <= 1'b0;
					end
					MODE_CLR_RX: begin
						rx_head_q <= '0;
						rx_tail_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// output register; ring read data is valid in the cycle after accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pend_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			line_tx_valid <= tx_pop_s1;
			line_tx_byte  <= tx_pop_s1 ? tx_rdata : '0;
			host_rx_valid <= rx_pop_s1;
			host_rx_byte  <= rx_pop_s1 ? rx_rdata : '0;
			stored        <= stored_s1;
			timeout_seen  <= to_seen_s1;
			driver_enable <= drv_s1;
		end
	end

endmodule

### verif/rs485_buffered_uart_queues_tb.sv
`timescale 1ns / 100ps

module rs485_buffered_uart_queues_tb;
	import rs485q_pkg::*;

	typedef struct packed {
		logic              line_tx_valid;
		logic [BYTE_W-1:0] line_tx_byte;
		logic              host_rx_valid;
		logic [BYTE_W-1:0] host_rx_byte;
		logic              stored;
		logic              timeout_seen;
		logic              driver_enable;
	} uart_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [MODE_W-1:0]    mode;
	logic [BYTE_W-1:0]    data_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic                 line_tx_valid;
	logic [BYTE_W-1:0]    line_tx_byte;
	logic                 host_rx_valid;
	logic [BYTE_W-1:0]    host_rx_byte;
	logic                 stored;
	logic                 timeout_seen;
	logic                 driver_enable;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	rs485_buffered_uart_queues dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_tx_valid (line_tx_valid),
		.line_tx_byte  (line_tx_byte),
		.host_rx_valid (host_rx_valid),
		.host_rx_byte  (host_rx_byte),
		.stored        (stored),
		.timeout_seen  (timeout_seen),
		.driver_enable (driver_enable),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predicted block state
	logic [BYTE_W-1:0]  rx_buf [RING_SIZE];
	logic [BYTE_W-1:0]  tx_buf [RING_SIZE];
	logic [PTR_W-1:0]   rx_wr, rx_rd, tx_wr, tx_rd;
	logic [DELAY_W-1:0] delay_cnt;
	logic [SIL_W-1:0]   silence_cnt;
	logic               timeout_flag;
	logic               line_busy;
	logic [DELAY_W-1:0] cur_tx_delay;
	logic [SIL_W-1:0]   cur_to_reload;

	uart_result_t expected_results [$];
	uart_result_t exp_res;
	int           errors;
	int           hold_req;
	bit           no_idle;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == RING_SIZE - 1) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic uart_result_t predict_step(input logic [MODE_W-1:0] m,
			input logic [BYTE_W-1:0] d);
		uart_result_t r;
		r = '0;
		case (m)
			MODE_RX_BYTE: begin
				if (!line_busy) begin
					if (ptr_inc(rx_wr) != rx_rd) begin
						rx_buf[rx_wr] = d;
						rx_wr = ptr_inc(rx_wr);
						r.stored = 1'b1;
					end
					silence_cnt = cur_to_reload;
					delay_cnt = cur_tx_delay;
				end
			end
			MODE_TX_READY: begin
				if (delay_cnt == 0 && tx_wr != tx_rd) begin
					r.line_tx_valid = 1'b1;
					r.line_tx_byte = tx_buf[tx_rd];
					tx_rd = ptr_inc(tx_rd);
					line_busy = 1'b1;
				end
			end
			MODE_TX_DONE: begin
				if (tx_wr == tx_rd)
					line_busy = 1'b0;
			end
			MODE_HOST_WR: begin
				if (ptr_inc(tx_wr) != tx_rd) begin
					tx_buf[tx_wr] = d;
					tx_wr = ptr_inc(tx_wr);
					r.stored = 1'b1;
				end
			end
			MODE_HOST_RD: begin
				if (rx_wr != rx_rd) begin
					r.host_rx_valid = 1'b1;
					r.host_rx_byte = rx_buf[rx_rd];
					rx_rd = ptr_inc(rx_rd);
				end
			end
			MODE_TICK: begin
				if (delay_cnt != 0)
					delay_cnt = delay_cnt - DELAY_W'(1);
				if (silence_cnt != 0) begin
					silence_cnt = silence_cnt - SIL_W'(1);
					if (silence_cnt == 0)
						timeout_flag = 1'b1;
				end
			end
			MODE_CHK_TO: begin
				r.timeout_seen = timeout_flag;
				timeout_flag = 1'b0;
			end
			MODE_CLR_RX: begin
				rx_wr = '0;
				rx_rd = '0;
			end
			default: ;
		endcase
		r.driver_enable = line_busy;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
			input logic [BYTE_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result transaction: expected none, actual %0h", $time,
					{line_tx_valid, line_tx_byte, host_rx_valid, host_rx_byte,
					 stored, timeout_seen, driver_enable});
				errors++;
			end else begin
				exp_res = expected_results.pop_front();
				check_field("line_tx_valid", BYTE_W'(exp_res.line_tx_valid),
					BYTE_W'(line_tx_valid));
				check_field("line_tx_byte", exp_res.line_tx_byte, line_tx_byte);
				check_field("host_rx_valid", BYTE_W'(exp_res.host_rx_valid),
					BYTE_W'(host_rx_valid));
				check_field("host_rx_byte", exp_res.host_rx_byte, host_rx_byte);
				check_field("stored", BYTE_W'(exp_res.stored), BYTE_W'(stored));
				check_field("timeout_seen", BYTE_W'(exp_res.timeout_seen),
					BYTE_W'(timeout_seen));
				check_field("driver_enable", BYTE_W'(exp_res.driver_enable),
					BYTE_W'(driver_enable));
			end
		end
	end

	// result sink: random stall per transaction, plus an optional long hold-off
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			while (hold_req > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				hold_req--;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= d;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_step(m, d));
	endtask

	// drop valid, wait for every outstanding result, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_TX_DELAY)
			cur_tx_delay = val;
		else if (idx == REG_TO_RELOAD)
			cur_to_reload = val[SIL_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] rnd_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(input int profile);
		int r;
		r = $urandom_range(0, 99);
		case (profile)
			1: begin
				if (r < 45) return MODE_RX_BYTE;
				if (r < 85) return MODE_HOST_WR;
				if (r < 90) return MODE_TICK;
				if (r < 95) return MODE_TX_READY;
				return MODE_CHK_TO;
			end
			2: begin
				if (r < 25) return MODE_HOST_RD;
				if (r < 50) return MODE_TX_READY;
				if (r < 65) return MODE_TX_DONE;
				if (r < 85) return MODE_TICK;
				if (r < 92) return MODE_CHK_TO;
				if (r < 96) return MODE_RX_BYTE;
				return MODE_CLR_RX;
			end
			default: begin
				if (r < 20) return MODE_RX_BYTE;
				if (r < 35) return MODE_TX_READY;
				if (r < 45) return MODE_TX_DONE;
				if (r < 65) return MODE_HOST_WR;
				if (r < 80) return MODE_HOST_RD;
				if (r < 92) return MODE_TICK;
				if (r < 97) return MODE_CHK_TO;
				return MODE_CLR_RX;
			end
		endcase
	endfunction

	task automatic test_directed();
		send_item(MODE_HOST_RD, rnd_byte());   // empty rx queue
		send_item(MODE_TX_READY, rnd_byte());  // empty tx queue
		send_item(MODE_RX_BYTE, 8'h00);
		send_item(MODE_RX_BYTE, 8'hFF);
		send_item(MODE_HOST_RD, rnd_byte());
		send_item(MODE_HOST_RD, rnd_byte());
		send_item(MODE_CHK_TO, rnd_byte());
		repeat (5) send_item(MODE_TICK, rnd_byte());
		send_item(MODE_CHK_TO, rnd_byte());
		send_item(MODE_CHK_TO, rnd_byte());
		send_item(MODE_HOST_WR, 8'hA5);
		send_item(MODE_HOST_WR, 8'h5A);
		send_item(MODE_TX_READY, rnd_byte());
		send_item(MODE_RX_BYTE, 8'h3C);        // echo while driving
		send_item(MODE_TX_DONE, rnd_byte());   // queue not empty, keeps line
		send_item(MODE_TX_READY, rnd_byte());
		send_item(MODE_TX_DONE, rnd_byte());
		send_item(MODE_RX_BYTE, 8'h11);
		send_item(MODE_CLR_RX, rnd_byte());
		send_item(MODE_HOST_RD, rnd_byte());
		drain();
	endtask

	task automatic test_tx_delay();
		write_reg(REG_TX_DELAY, 16'd3);
		send_item(MODE_RX_BYTE, rnd_byte());
		send_item(MODE_HOST_WR, rnd_byte());
		send_item(MODE_TX_READY, rnd_byte());  // still delaying
		repeat (3) send_item(MODE_TICK, rnd_byte());
		send_item(MODE_TX_READY, rnd_byte());
		send_item(MODE_TX_DONE, rnd_byte());
		send_item(MODE_HOST_RD, rnd_byte());
		drain();
	endtask

	task automatic test_zero_reload();
		write_reg(REG_TO_RELOAD, 16'd0);
		write_reg(REG_TX_DELAY, 16'd0);
		send_item(MODE_CHK_TO, rnd_byte());
		send_item(MODE_RX_BYTE, rnd_byte());
		repeat (2) send_item(MODE_TICK, rnd_byte());
		send_item(MODE_CHK_TO, rnd_byte());
		send_item(MODE_HOST_RD, rnd_byte());
		write_reg(REG_TO_RELOAD, 16'd5);
	endtask

	task automatic test_ring_full();
		send_item(MODE_TX_DONE, rnd_byte());
		send_item(MODE_CLR_RX, rnd_byte());
		repeat (RING_SIZE) send_item(MODE_RX_BYTE, rnd_byte());
		repeat (RING_SIZE) send_item(MODE_HOST_RD, rnd_byte());
		repeat (RING_SIZE) send_item(MODE_HOST_WR, rnd_byte());
		repeat (RING_SIZE) send_item(MODE_TX_READY, rnd_byte());
		send_item(MODE_TX_DONE, rnd_byte());
		drain();
	endtask

	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_req = 200;
		repeat (12) send_item(pick_mode(0), rnd_byte());
		no_idle = 1'b0;
		drain();
		repeat (6) send_item(pick_mode(0), rnd_byte());
		drain();
	endtask

	task automatic run_random_phase(input int n, input logic [CFG_W-1:0] dly,
			input logic [CFG_W-1:0] reload, input bit quiet);
		int profile;
		write_reg(REG_TX_DELAY, dly);
		write_reg(REG_TO_RELOAD, reload);
		no_idle = quiet;
		profile = 0;
		for (int i = 0; i < n; i++) begin
			if (i % 48 == 0)
				profile = $urandom_range(0, 2);
			send_item(pick_mode(profile), rnd_byte());
		end
		no_idle = 1'b0;
		drain();
	endtask

	task automatic test_random();
		run_random_phase(60, 16'd0, 16'd1, 1'b0);
		run_random_phase(30, 16'hFFFF, 16'd255, 1'b0);
		run_random_phase(60, CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(1, 30)),
			1'b0);
		run_random_phase(40, 16'd2, 16'd3, 1'b1);
		run_random_phase(50, CFG_W'($urandom_range(0, 7)), 16'd255, 1'b0);
	endtask

	initial begin
		errors = 0;
		hold_req = 0;
		no_idle = 1'b0;
		in_valid = 1'b0;
		mode = MODE_RX_BYTE;
		data_byte = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TX_DELAY;
		cfg_data = '0;
		for (int i = 0; i < RING_SIZE; i++) begin
			rx_buf[i] = '0;
			tx_buf[i] = '0;
		end
		rx_wr = '0;
		rx_rd = '0;
		tx_wr = '0;
		tx_rd = '0;
		delay_cnt = '0;
		silence_cnt = '0;
		timeout_flag = 1'b0;
		line_busy = 1'b0;
		cur_tx_delay = '0;
		cur_to_reload = TO_RELOAD_RST;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_tx_delay();
		test_zero_reload();
		test_ring_full();
		test_backpressure();
		test_random();

		drain();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
design/rs485q_pkg.sv
design/rs485q_ram.sv
design/rs485_buffered_uart_queues.sv
verif/rs485_buffered_uart_queues_tb.sv
